// File: design/bme_pkg.sv
`default_nettype none

package bme_pkg;

  // Configuration register widths and reset values
  localparam int SIZE_W = 11;
  localparam int SHAPE_W = 2;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int MIN_SIZE = 3;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam logic [SIZE_W-1:0] RST_IMG_WIDTH = 11'd640;
  localparam logic [SIZE_W-1:0] RST_IMG_HEIGHT = 11'd480;

  localparam int PIX_W = 8;
  localparam logic [PIX_W-1:0] PIX_WHITE = 8'hFF;
  localparam logic [PIX_W-1:0] PIX_BLACK = 8'h00;

  // Register map, one 32-bit register every four bytes
  typedef enum logic [1:0] {
    REG_IMG_WIDTH     = 2'd0,
    REG_IMG_HEIGHT    = 2'd1,
    REG_OPERATION     = 2'd2,
    REG_ELEMENT_SHAPE = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    OP_ERODE  = 1'b0,
    OP_DILATE = 1'b1
  } morph_op_e;

  localparam logic [SHAPE_W-1:0] SHAPE_HORIZ = 2'd0;
  localparam logic [SHAPE_W-1:0] SHAPE_VERT = 2'd1;
  localparam logic [SHAPE_W-1:0] SHAPE_CROSS = 2'd2;

  localparam morph_op_e RST_OPERATION = OP_ERODE;
  localparam logic [SHAPE_W-1:0] RST_ELEMENT_SHAPE = SHAPE_CROSS;

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

endpackage

`default_nettype wire

// File: design/binary_morph_erode_dilate.sv
// Binary morphology on a raster-order 8-bit pixel stream: one erosion or dilation
// pass with a horizontal 1x3, vertical 3x1 or 3x3 cross structuring element.
// Input words arrive on the s_axis channel: tdata holds the pixel and tuser marks a
// flush word. Result words leave on m_axis: tdata is 0 or 255, tlast marks the last
// pixel of an output row and tuser the last pixel of the frame.
// Output row k is produced while input row k+1 arrives, so the first input row gives
// no result words. After the last pixel of the frame, img_width flush words drain the
// final row; flush words at other times and pixels during the drain are swallowed.
// A result word is registered at the edge that accepts its input word. One word is
// accepted every clock cycle while s_axis_tready is high; the line buffers are read
// one column ahead, so the window never waits on a memory port.
// An output register plus one skid entry part the two sides: while the receiver
// stalls, one further result word is still taken into the skid entry, after which
// s_axis_tready drops until that entry empties; words that give no result are
// accepted up to that point. Reset returns the counters and the drain flag to the
// start of a frame and the registers to 640 x 480, erosion, cross; line-buffer
// contents are not cleared. Configuration is to be written over the APB port only while
// the stream is idle; the block itself does not enforce this.
`default_nettype none

module binary_morph_erode_dilate #(
  parameter int MAX_WIDTH = bme_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bme_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Input stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [bme_pkg::PIX_W-1:0]       s_axis_tdata,  // [7:0] pixel
  input  wire logic                            s_axis_tuser,  // [0] func (1 = flush)
  // Output stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [bme_pkg::PIX_W-1:0]            m_axis_tdata,  // [7:0] pixel_out
  output logic                                 m_axis_tlast,  // end_of_line
  output logic                                 m_axis_tuser,  // [0] end_of_frame
  // Configuration port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [bme_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [bme_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [bme_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                 pready
);

  import bme_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WCMP = (CW + 1 > SIZE_W) ? CW + 1 : SIZE_W;
  localparam int HCMP = (RW + 1 > SIZE_W) ? RW + 1 : SIZE_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [SIZE_W-1:0]  img_width_q;
  logic [SIZE_W-1:0]  img_height_q;
  morph_op_e          operation_q;
  logic [SHAPE_W-1:0] element_shape_q;
  logic               cfg_wr;
  cfg_reg_e           cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = cfg_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_width_q     <= RST_IMG_WIDTH;
      img_height_q    <= RST_IMG_HEIGHT;
      operation_q     <= RST_OPERATION;
      element_shape_q <= RST_ELEMENT_SHAPE;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_IMG_WIDTH:     img_width_q <= pwdata[SIZE_W-1:0];
        REG_IMG_HEIGHT:    img_height_q <= pwdata[SIZE_W-1:0];
        REG_OPERATION:     operation_q <= morph_op_e'(pwdata[0]);
        REG_ELEMENT_SHAPE: element_shape_q <= pwdata[SHAPE_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_IMG_WIDTH:     prdata = APB_DATA_W'(img_width_q);
      REG_IMG_HEIGHT:    prdata = APB_DATA_W'(img_height_q);
      REG_OPERATION:     prdata = APB_DATA_W'(operation_q);
      REG_ELEMENT_SHAPE: prdata = APB_DATA_W'(element_shape_q);
    endcase
  end

  // Effective frame size, clamped to the supported range.
  logic [WCMP-1:0] w_eff;
  logic [HCMP-1:0] h_eff;

  always_comb begin
    if (WCMP'(img_width_q) < WCMP'(MIN_SIZE)) begin
      w_eff = WCMP'(MIN_SIZE);
    end else if (WCMP'(img_width_q) > WCMP'(MAX_WIDTH)) begin
      w_eff = WCMP'(MAX_WIDTH);
    end else begin
      w_eff = WCMP'(img_width_q);
    end
    if (HCMP'(img_height_q) < HCMP'(MIN_SIZE)) begin
      h_eff = HCMP'(MIN_SIZE);
    end else if (HCMP'(img_height_q) > HCMP'(MAX_HEIGHT)) begin
      h_eff = HCMP'(MAX_HEIGHT);
    end else begin
      h_eff = HCMP'(img_height_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Position counters and drain flag
  // ---------------------------------------------------------------------------
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          drain_q, drain_d;
  logic [PIX_W-1:0] left_q, left_d;

  logic in_acc;
  logic last_col, has_cols, has_rows, last_row;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign last_col = (WCMP'(col_q) + WCMP'(1)) >= w_eff;
  assign has_cols = (col_q != '0) && ((WCMP'(col_q) + WCMP'(2)) <= w_eff);
  assign last_row = (HCMP'(row_q) + HCMP'(1)) >= h_eff;
  // The output row is row_q - 1 outside the drain; it has a full vertical window when it is neither
  // the first nor the last row of the frame.
  assign has_rows = (HCMP'(row_q) >= HCMP'(2)) && ((HCMP'(row_q) + HCMP'(1)) <= h_eff);

  // ---------------------------------------------------------------------------
  // Line buffers. Both are read every cycle at the column the next word will use,
  // so the registered read data always belongs to the current column.
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] above_mem [MAX_WIDTH];
  logic [PIX_W-1:0] two_above_mem [MAX_WIDTH];
  logic [PIX_W-1:0] above_q, above_next_q, two_above_q;
  logic [CW-1:0]    rd_addr_next;
  logic             line_wr;

  assign rd_addr_next = (col_d == CW'(MAX_WIDTH - 1)) ? '0 : col_d + CW'(1);

  always_ff @(posedge clk_i) begin
    if (line_wr) begin
      above_mem[col_q]     <= s_axis_tdata;
      two_above_mem[col_q] <= above_q;
    end
    above_q      <= above_mem[col_d];
    above_next_q <= above_mem[rd_addr_next];
    two_above_q  <= two_above_mem[col_d];
  end

  // ---------------------------------------------------------------------------
  // Window and decision
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] win_up, win_left, win_mid, win_right, win_down;
  logic             any_white, any_black, covered_ok;
  logic [PIX_W-1:0] res_pix;
  logic             res_valid, res_eol, res_eof;

  assign win_up    = two_above_q;
  assign win_mid   = above_q;
  assign win_left  = (col_q != '0) ? left_q : PIX_BLACK;
  assign win_right = last_col ? PIX_BLACK : above_next_q;
  assign win_down  = s_axis_tdata;

  always_comb begin
    case (element_shape_q)
      SHAPE_HORIZ: begin
        covered_ok = has_cols;
        any_white  = (win_left == PIX_WHITE) || (win_mid == PIX_WHITE) ||
                     (win_right == PIX_WHITE);
        any_black  = (win_left == PIX_BLACK) || (win_mid == PIX_BLACK) ||
                     (win_right == PIX_BLACK);
      end
      SHAPE_VERT: begin
        covered_ok = has_rows && !drain_q;
        any_white  = (win_up == PIX_WHITE) || (win_mid == PIX_WHITE) ||
                     (win_down == PIX_WHITE);
        any_black  = (win_up == PIX_BLACK) || (win_mid == PIX_BLACK) ||
                     (win_down == PIX_BLACK);
      end
      default: begin
        // The cross; the unused shape code behaves the same way.
        covered_ok = has_rows && has_cols && !drain_q;
        any_white  = (win_up == PIX_WHITE) || (win_left == PIX_WHITE) ||
                     (win_mid == PIX_WHITE) || (win_right == PIX_WHITE) ||
                     (win_down == PIX_WHITE);
        any_black  = (win_up == PIX_BLACK) || (win_left == PIX_BLACK) ||
                     (win_mid == PIX_BLACK) || (win_right == PIX_BLACK) ||
                     (win_down == PIX_BLACK);
      end
    endcase

    if (!covered_ok) begin
      res_pix = PIX_WHITE;
    end else if (operation_q == OP_DILATE) begin
      res_pix = any_black ? PIX_BLACK : PIX_WHITE;
    end else begin
      res_pix = any_white ? PIX_WHITE : PIX_BLACK;
    end
  end

  // Next state of the counters, and whether the accepted word gives a result.
  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    drain_d   = drain_q;
    left_d    = left_q;
    line_wr   = 1'b0;
    res_valid = 1'b0;
    res_eol   = last_col;
    res_eof   = 1'b0;
    if (in_acc) begin
      if (drain_q) begin
        if (s_axis_tuser == FUNC_FLUSH) begin
          res_valid = 1'b1;
          res_eof   = last_col;
          left_d    = win_mid;
          if (last_col) begin
            drain_d = 1'b0;
            col_d   = '0;
            row_d   = '0;
          end else begin
            col_d = col_q + CW'(1);
          end
        end
      end else if (s_axis_tuser == FUNC_PIXEL) begin
        res_valid = (row_q != '0);
        line_wr   = 1'b1;
        left_d    = win_mid;
        if (last_col) begin
          col_d = '0;
          if (last_row) begin
            drain_d = 1'b1;
          end else begin
            row_d = row_q + RW'(1);
          end
        end else begin
          col_d = col_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      drain_q <= 1'b0;
      left_q  <= PIX_BLACK;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      drain_q <= drain_d;
      left_q  <= left_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register with one skid entry
  // ---------------------------------------------------------------------------
  logic             out_valid_q, skid_valid_q;
  logic [PIX_W-1:0] out_pix_q, skid_pix_q;
  logic             out_eol_q, out_eof_q, skid_eol_q, skid_eof_q;
  logic             out_take;

  assign out_take      = out_valid_q && m_axis_tready;
  assign s_axis_tready = !skid_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pix_q;
  assign m_axis_tlast  = out_eol_q;
  assign m_axis_tuser  = out_eof_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_q || out_take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_pix_q <= skid_pix_q;
        out_eol_q <= skid_eol_q;
        out_eof_q <= skid_eof_q;
      end
    end else if (res_valid) begin
      if (!out_valid_q || out_take) begin
        out_pix_q <= res_pix;
        out_eol_q <= res_eol;
        out_eof_q <= res_eof;
      end else begin
        skid_pix_q <= res_pix;
        skid_eol_q <= res_eol;
        skid_eof_q <= res_eof;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds a word while the output register is empty");

  a_eof_is_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!m_axis_tuser || m_axis_tlast))
    else $error("end of frame without end of line");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WCMP'(col_q) < WCMP'(MAX_WIDTH))
    else $error("column counter beyond the line buffer");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |=> out_valid_q)
    else $error("accepted result word was lost");

  a_drain_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_q |-> !line_wr)
    else $error("line buffer written during the drain");

endmodule

`default_nettype wire
